/* rtl/smb_pkg.sv */
// Package for the sprite motion bounce block: widths, register indexes,
// register reset values. No dependencies.
package smb_pkg;

  localparam int ACC_W    = 16;
  localparam int SCR_W    = 12;
  localparam int CFG_IX_W = 3;
  localparam int CFG_D_W  = 16;

  typedef logic [CFG_IX_W-1:0] cfg_ix_t;

  localparam cfg_ix_t REG_X_LIMIT  = 3'd0;
  localparam cfg_ix_t REG_Y_LIMIT  = 3'd1;
  localparam cfg_ix_t REG_GAIN     = 3'd2;
  localparam cfg_ix_t REG_FRICTION = 3'd3;
  localparam cfg_ix_t REG_FRAME_MS = 3'd4;

  localparam logic [11:0] X_LIMIT_RST  = 12'd320;
  localparam logic [11:0] Y_LIMIT_RST  = 12'd480;
  localparam logic [15:0] GAIN_RST     = 16'd41943;
  localparam logic [15:0] FRICTION_RST = 16'd839;
  localparam logic [7:0]  FRAME_MS_RST = 8'd16;

endpackage

/* rtl/smb_item_if.sv */
// Input item channel: valid/ready plus kind and accelerometer readings.
// Depends on smb_pkg.
interface smb_item_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic signed [smb_pkg::ACC_W-1:0] accel_x;
  logic signed [smb_pkg::ACC_W-1:0] accel_y;
  modport source(output valid, kind, accel_x, accel_y, input ready);
  modport sink(input valid, kind, accel_x, accel_y, output ready);
endinterface

/* rtl/smb_result_if.sv */
// Result channel: valid/ready plus integer screen position.
// Depends on smb_pkg.
interface smb_result_if;
  logic                      valid;
  logic                      ready;
  logic [smb_pkg::SCR_W-1:0] screen_x;
  logic [smb_pkg::SCR_W-1:0] screen_y;
  modport source(output valid, screen_x, screen_y, input ready);
  modport sink(input valid, screen_x, screen_y, output ready);
endinterface

/* rtl/smb_cfg_if.sv */
// Configuration write channel: valid/ready, register index, write data.
// Depends on smb_pkg.
interface smb_cfg_if;
  logic                        valid;
  logic                        ready;
  smb_pkg::cfg_ix_t            index;
  logic [smb_pkg::CFG_D_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/sprite_motion_bounce_step.sv */
// Sprite motion step: accelerometer drive, friction, wall bounce.
// Place item: straight to result. Advance item: gain, 32-step square root,
// a 32-step divide per axis for friction (none if friction stops the point),
// then move and bounce. One item at a time; ready only when idle.
// rst (synchronous) clears position and velocity and loads register defaults.
// Depends on smb_pkg, smb_item_if, smb_result_if, smb_cfg_if.
module sprite_motion_bounce_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  smb_item_if.sink            items,
  smb_result_if.source        results,
  smb_cfg_if.sink             cfg
);

  localparam int PW    = 12 + FRAC_BITS;
  localparam int NW    = ((PW > 40) ? PW : 40) + 2;
  localparam int SH    = 32 - FRAC_BITS;
  localparam int FW    = (FRAC_BITS >= 16) ? FRAC_BITS : 16;
  localparam int FSH_L = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int FSH_R = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam longint VCAP  = 64'sd32767 <<< FRAC_BITS;
  localparam longint VMAX_L = (VCAP > 64'sd2147483647) ? 64'sd2147483647 : VCAP;
  localparam logic signed [33:0] VMAX = VMAX_L[33:0];

  typedef enum logic [14:0] {
    ST_IDLE = 15'b000000000000001,
    ST_G    = 15'b000000000000010,
    ST_V    = 15'b000000000000100,
    ST_QX   = 15'b000000000001000,
    ST_QY   = 15'b000000000010000,
    ST_SUM  = 15'b000000000100000,
    ST_SQRT = 15'b000000001000000,
    ST_DEC  = 15'b000000010000000,
    ST_F    = 15'b000000100000000,
    ST_DI   = 15'b000001000000000,
    ST_D    = 15'b000010000000000,
    ST_U    = 15'b000100000000000,
    ST_I    = 15'b001000000000000,
    ST_P    = 15'b010000000000000,
    ST_DONE = 15'b100000000000000
  } state_t;

  state_t state;

  // configuration
  logic [11:0] x_limit, y_limit;
  logic [15:0] accel_gain, friction_step;
  logic [7:0]  frame_ms;

  // motion state
  logic [PW-1:0]      position_x, position_y;
  logic signed [31:0] velocity_x, velocity_y;
  logic signed [16:0] ax, ay;
  logic               axis;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;
  logic signed [63:0] mul_p;

  // square root and divider
  logic [63:0] sq_n, sq_r, sq_bit, sq_sum;
  logic [31:0] rem, dq;
  logic [4:0]  cnt;
  logic [32:0] rem2;
  logic        ge;

  logic [smb_pkg::SCR_W-1:0] screen_x, screen_y;
  logic                      out_valid;

  // per-axis selections
  logic signed [31:0] vsel, vhalf, vcut;
  logic [PW-1:0]      psel;
  logic [11:0]        lsel;
  logic signed [33:0] gshift, gsum, vsat;
  logic [32:0]        vmag;
  logic [FW-1:0]      fric_f;
  logic [31:0]        spd;
  logic signed [NW-1:0] np, top;
  logic [PW-1:0]      pnew;
  logic               bounce;

  assign vsel  = axis ? velocity_y : velocity_x;
  assign psel  = axis ? position_y : position_x;
  assign lsel  = axis ? y_limit : x_limit;
  assign spd   = sq_r[31:0];
  assign fric_f = (FRAC_BITS >= 16) ? (FW'(friction_step) << FSH_L)
                                    : (FW'(friction_step) >> FSH_R);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_G: begin
        mul_a = 33'(axis ? ay : ax);
        mul_b = $signed({17'd0, accel_gain});
      end
      ST_QX: begin
        mul_a = 33'(velocity_x);
        mul_b = 33'(velocity_x);
      end
      ST_QY: begin
        mul_a = 33'(velocity_y);
        mul_b = 33'(velocity_y);
      end
      ST_F: begin
        mul_a = $signed(vmag);
        mul_b = $signed(33'(fric_f));
      end
      ST_I: begin
        mul_a = 33'(vsel);
        mul_b = $signed({25'd0, frame_ms});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_comb begin
    gshift = 34'(mul_p >>> SH);
    gsum   = 34'(vsel) + gshift;
    if (gsum > VMAX) begin
      vsat = VMAX;
    end else if (gsum < -VMAX) begin
      vsat = -VMAX;
    end else begin
      vsat = gsum;
    end
    vmag  = vsel[31] ? 33'(-33'(vsel)) : 33'(vsel);
    vcut  = vsel[31] ? 32'(vsel + $signed({1'b0, dq})) : 32'(vsel - $signed({1'b0, dq}));
    vhalf = -((vsel + $signed({31'd0, vsel[31]})) >>> 1);
    np    = $signed({{(NW-PW){1'b0}}, psel}) + $signed({{(NW-40){mul_p[39]}}, mul_p[39:0]});
    top   = $signed({{(NW-PW){1'b0}}, lsel, {FRAC_BITS{1'b0}}});
    bounce = 1'b1;
    if (np > top) begin
      pnew = {lsel, {FRAC_BITS{1'b0}}};
    end else if (np < 0) begin
      pnew = '0;
    end else begin
      pnew   = np[PW-1:0];
      bounce = 1'b0;
    end
    sq_sum = sq_r + sq_bit;
    rem2   = {rem, dq[31]};
    ge     = rem2 >= {1'b0, spd};
  end

  assign items.ready   = (state == ST_IDLE);
  assign cfg.ready     = 1'b1;
  assign results.valid = out_valid;
  assign results.screen_x = screen_x;
  assign results.screen_y = screen_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit       <= smb_pkg::X_LIMIT_RST;
      y_limit       <= smb_pkg::Y_LIMIT_RST;
      accel_gain    <= smb_pkg::GAIN_RST;
      friction_step <= smb_pkg::FRICTION_RST;
      frame_ms      <= smb_pkg::FRAME_MS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        smb_pkg::REG_X_LIMIT:  x_limit       <= cfg.data[11:0];
        smb_pkg::REG_Y_LIMIT:  y_limit       <= cfg.data[11:0];
        smb_pkg::REG_GAIN:     accel_gain    <= cfg.data;
        smb_pkg::REG_FRICTION: friction_step <= cfg.data;
        smb_pkg::REG_FRAME_MS: frame_ms      <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_full[63:0];
    if (rst) begin
      state      <= ST_IDLE;
      position_x <= '0;
      position_y <= '0;
      velocity_x <= '0;
      velocity_y <= '0;
      axis       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (state == ST_DONE && (!out_valid || results.ready)) out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          axis <= 1'b0;
          if (items.valid) begin
            ax <= 17'(items.accel_x);
            ay <= -17'(items.accel_y);
            if (items.kind) begin
              position_x <= {1'b0, x_limit[11:1], {FRAC_BITS{1'b0}}};
              position_y <= {1'b0, y_limit[11:1], {FRAC_BITS{1'b0}}};
              velocity_x <= '0;
              velocity_y <= '0;
              state      <= ST_DONE;
            end else begin
              state <= ST_G;
            end
          end
        end
        ST_G: state <= ST_V;
        ST_V: begin
          if (axis) velocity_y <= vsat[31:0];
          else      velocity_x <= vsat[31:0];
          axis  <= ~axis;
          state <= axis ? ST_QX : ST_G;
        end
        ST_QX: state <= ST_QY;
        ST_QY: begin
          sq_n  <= mul_p;
          state <= ST_SUM;
        end
        ST_SUM: begin
          sq_n   <= sq_n + mul_p;
          sq_r   <= '0;
          sq_bit <= 64'd1 << 62;
          state  <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_n >= sq_sum) begin
            sq_n <= sq_n - sq_sum;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) state <= ST_DEC;
        end
        ST_DEC: begin
          if (spd == '0) begin
            state <= ST_I;
          end else if (spd > 32'(fric_f)) begin
            state <= ST_F;
          end else begin
            velocity_x <= '0;
            velocity_y <= '0;
            state      <= ST_I;
          end
        end
        ST_F: state <= ST_DI;
        ST_DI: begin
          // quotient is at most friction, so the high word is below speed
          rem   <= mul_p[63:32];
          dq    <= mul_p[31:0];
          cnt   <= '0;
          state <= ST_D;
        end
        ST_D: begin
          rem <= ge ? 32'(rem2 - {1'b0, spd}) : rem2[31:0];
          dq  <= {dq[30:0], ge};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) state <= ST_U;
        end
        ST_U: begin
          if (axis) velocity_y <= vcut;
          else      velocity_x <= vcut;
          axis  <= ~axis;
          state <= axis ? ST_I : ST_F;
        end
        ST_I: state <= ST_P;
        ST_P: begin
          if (axis) begin
            position_y <= pnew;
            if (bounce) velocity_y <= vhalf;
          end else begin
            position_x <= pnew;
            if (bounce) velocity_x <= vhalf;
          end
          axis  <= ~axis;
          state <= axis ? ST_DONE : ST_I;
        end
        ST_DONE: begin
          if (!out_valid || results.ready) begin
            screen_x  <= position_x[PW-1:FRAC_BITS];
            screen_y  <= position_y[PW-1:FRAC_BITS];
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/smb_motion_checker.sv */
`timescale 1ns / 1ps
// Checker for the sprite motion bounce block: watches item, config and result
// channels, predicts screen positions, compares. Depends on smb_pkg and the channel interfaces.
module smb_motion_checker (
  input  logic   clk,
  input  logic   rst,
  smb_item_if    items,
  smb_result_if  results,
  smb_cfg_if     cfg,
  output int     fail_count,
  output int     outstanding,
  output int     positions_seen
);
  import smb_pkg::*;

  localparam int FB = 16;
  localparam longint VEL_LIM = longint'(32767) <<< FB;

  typedef struct packed {
    logic [SCR_W-1:0] sx;
    logic [SCR_W-1:0] sy;
  } screen_pos_t;

  screen_pos_t pos_q[$];

  logic [11:0] lim_x, lim_y;
  logic [15:0] gain, fric;
  logic [7:0]  frame;
  longint      px, py, vx, vy;

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clamp_vel(longint v);
    if (v > VEL_LIM) return VEL_LIM;
    if (v < -VEL_LIM) return -VEL_LIM;
    return v;
  endfunction

  function automatic longint shorten(longint v, longint f, longint s);
    longint m, d;
    m = (v < 0) ? -v : v;
    d = (m * f) / s;
    return (v < 0) ? v + d : v - d;
  endfunction

  task automatic move_axis(inout longint p, inout longint v, input logic [11:0] lim);
    longint top, np;
    top = longint'(lim) <<< FB;
    np = p + v * longint'(frame);
    if (np > top) begin
      np = top;
      v = -v / 2;
    end else if (np < 0) begin
      np = 0;
      v = -v / 2;
    end
    p = np;
  endtask

  task automatic advance_frame(input logic kind, input logic signed [15:0] ax,
                               input logic signed [15:0] ay);
    longint gx, gy, s, f;
    if (kind) begin
      px = longint'(lim_x >> 1) <<< FB;
      py = longint'(lim_y >> 1) <<< FB;
      vx = 0;
      vy = 0;
    end else begin
      gx = longint'(ax) * longint'(gain);
      gy = -longint'(ay) * longint'(gain);
      vx = clamp_vel(vx + (gx >>> (32 - FB)));
      vy = clamp_vel(vy + (gy >>> (32 - FB)));
      s = longint'(root_floor(longint'(vx * vx + vy * vy)));
      f = longint'(fric);
      if (s > 0) begin
        if (s > f) begin
          vx = shorten(vx, f, s);
          vy = shorten(vy, f, s);
        end else begin
          vx = 0;
          vy = 0;
        end
      end
      move_axis(px, vx, lim_x);
      move_axis(py, vy, lim_y);
    end
    pos_q.push_back('{sx: SCR_W'(px >>> FB), sy: SCR_W'(py >>> FB)});
  endtask

  always @(posedge clk) begin
    screen_pos_t exp_pos;
    if (rst) begin
      lim_x <= X_LIMIT_RST;
      lim_y <= Y_LIMIT_RST;
      gain  <= GAIN_RST;
      fric  <= FRICTION_RST;
      frame <= FRAME_MS_RST;
      px = 0; py = 0; vx = 0; vy = 0;
      pos_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_X_LIMIT:  lim_x <= cfg.data[11:0];
          REG_Y_LIMIT:  lim_y <= cfg.data[11:0];
          REG_GAIN:     gain  <= cfg.data;
          REG_FRICTION: fric  <= cfg.data;
          REG_FRAME_MS: frame <= cfg.data[7:0];
          default: ;
        endcase
      end
      if (items.valid && items.ready)
        advance_frame(items.kind, items.accel_x, items.accel_y);
      if (results.valid && results.ready) begin
        positions_seen <= positions_seen + 1;
        if (pos_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("[%0t] unexpected result x=%0d y=%0d", $time,
                     results.screen_x, results.screen_y);
        end else begin
          exp_pos = pos_q.pop_front();
          if (results.screen_x !== exp_pos.sx || results.screen_y !== exp_pos.sy) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("[%0t] position mismatch: exp x=%0d y=%0d got x=%0d y=%0d",
                       $time, exp_pos.sx, exp_pos.sy, results.screen_x, results.screen_y);
          end
        end
      end
      outstanding <= pos_q.size();
    end
  end

  initial begin
    fail_count = 0;
    outstanding = 0;
    positions_seen = 0;
  end
endmodule

/* tb/sv/tb_sprite_motion_bounce_step.sv */
`timescale 1ns / 1ps
// Top testbench for sprite_motion_bounce_step: clock, reset, stimulus and verdict.
// Depends on smb_pkg, the channel interfaces, smb_motion_checker and the block.
module tb_sprite_motion_bounce_step;
  import smb_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int   fail_count, outstanding, positions_seen;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   frames_sent = 0;
  int   cfg_writes = 0;

  always #10 clk = ~clk;

  smb_item_if   items();
  smb_result_if results();
  smb_cfg_if    cfg();

  sprite_motion_bounce_step dut (
    .clk(clk), .rst(rst), .items(items), .results(results), .cfg(cfg)
  );

  smb_motion_checker chk (
    .clk(clk), .rst(rst), .items(items), .results(results), .cfg(cfg),
    .fail_count(fail_count), .outstanding(outstanding), .positions_seen(positions_seen)
  );

  always @(posedge clk) begin
    if (rst) results.ready <= 1'b0;
    else results.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_frame(input logic kind, input logic [15:0] ax, input logic [15:0] ay);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      items.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    items.valid   <= 1'b1;
    items.kind    <= kind;
    items.accel_x <= ax;
    items.accel_y <= ay;
    do @(posedge clk); while (!items.ready);
    frames_sent++;
  endtask

  // lowers item valid and waits until every position has come back
  task automatic drain;
    items.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_ix_t ix, input logic [15:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= ix;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg_writes++;
  endtask

  task automatic load_setup(input logic [15:0] xl, input logic [15:0] yl,
                            input logic [15:0] g, input logic [15:0] f,
                            input logic [15:0] fm);
    write_reg(REG_X_LIMIT, xl);
    write_reg(REG_Y_LIMIT, yl);
    write_reg(REG_GAIN, g);
    write_reg(REG_FRICTION, f);
    write_reg(REG_FRAME_MS, fm);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_accel();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 511) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_frames(input int n);
    for (int i = 0; i < n; i++) begin
      if (frames_sent > 600) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end else if (frames_sent > 320) begin
        send_idle_pct = 88; recv_idle_pct = 16;
      end
      send_frame($urandom_range(99) < 5, pick_accel(), pick_accel());
    end
  endtask

  initial begin
    items.valid = 0; items.kind = 0; items.accel_x = 0; items.accel_y = 0;
    cfg.valid = 0; cfg.index = REG_X_LIMIT; cfg.data = 0;
    results.ready = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 16; recv_idle_pct = 88;
    @(posedge clk);

    // directed: reset defaults, extremes, place, bounce
    send_frame(1'b0, 16'h0000, 16'h0000);
    send_frame(1'b1, 16'h1234, 16'hFFFF);
    send_frame(1'b0, 16'h7FFF, 16'h8000);
    send_frame(1'b0, 16'h7FFF, 16'h8000);
    send_frame(1'b0, 16'h8000, 16'h7FFF);
    send_frame(1'b0, 16'h0001, 16'hFFFF);
    send_frame(1'b0, 16'h0000, 16'h0000);
    drain();
    load_setup(16'd4095, 16'd4095, 16'hFFFF, 16'h0000, 16'd255);
    send_frame(1'b1, 16'h0000, 16'h0000);
    repeat (4) send_frame(1'b0, 16'h7FFF, 16'h7FFF);
    repeat (4) send_frame(1'b0, 16'h8000, 16'h8000);
    drain();
    // limits lowered below current position; stray register indexes ignored
    write_reg(REG_X_LIMIT, 16'hF000);
    write_reg(REG_Y_LIMIT, 16'd3);
    write_reg(3'd5, 16'hFFFF);
    write_reg(3'd7, 16'h0001);
    write_reg(REG_FRAME_MS, 16'h0100);
    cfg.valid <= 1'b0;
    send_frame(1'b0, 16'h0100, 16'h0100);
    send_frame(1'b0, 16'h0000, 16'h0000);
    drain();
    write_reg(REG_FRAME_MS, 16'd1);
    cfg.valid <= 1'b0;
    load_setup(16'd0, 16'd1, 16'h0000, 16'hFFFF, 16'd1);
    send_frame(1'b0, 16'h7FFF, 16'h8000);
    send_frame(1'b1, 16'h0000, 16'h0000);
    drain();

    load_setup(16'd320, 16'd480, 16'd41943, 16'd839, 16'd16);
    random_frames(200);
    drain();
    load_setup(16'd4095, 16'd4095, 16'hFFFF, 16'd20, 16'd255);
    random_frames(150);
    drain();
    load_setup(16'd100, 16'd50, 16'd4000, 16'd5000, 16'd40);
    random_frames(150);
    drain();
    load_setup(16'hFFFF, 16'd2000, 16'd20000, 16'd0, 16'd0);
    random_frames(120);
    drain();
    load_setup(16'd639, 16'd479, 16'd65000, 16'd65535, 16'd8);
    random_frames(140);
    drain();
    load_setup(16'd320, 16'd480, 16'd41943, 16'd839, 16'd16);
    random_frames(140);
    drain();

    $display("Covered %0d frames, %0d register writes, %0d positions checked.",
             frames_sent, cfg_writes, positions_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Timeout with %0d positions outstanding", outstanding);
    $display("Simulation FAILED");
    $finish;
  end
endmodule
